@@ design/vlan_learning_switch_forwarder_unit_macros.svh @@
// Assertion macros for the VLAN learning switch forwarder.
// Included by the top level; no other dependencies.
`ifndef VLAN_LEARNING_SWITCH_FORWARDER_UNIT_MACROS_SVH
`define VLAN_LEARNING_SWITCH_FORWARDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VLSF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define VLSF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define VLSF_ASSERT_NOW(label, ante, cons)
`define VLSF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/vlsf_pkg.sv @@
// Shared types, constants and port helper functions of the forwarder.
// No dependencies.
package vlsf_pkg;

   localparam int PORT_COUNT    = 8;
   localparam int TABLE_ENTRIES = 256;
   localparam int PORT_W        = 4;
   localparam int VLAN_W        = 12;
   localparam int MAC_W         = 48;
   localparam int MASK_W        = 8;
   localparam int CSR_W         = 48;
   localparam int CSR_IDX_W     = 4;
   localparam int GROUP_BIT     = 40;
   localparam int VLANS_W       = 2 * CSR_W;

   localparam logic [VLAN_W-1:0] DEFAULT_VLAN     = 12'd1;
   localparam logic [CSR_W-1:0]  ACCESS_VLAN_INIT = 48'h0010_0100_1001;

   typedef enum logic [1:0] {
      ACT_UNICAST   = 2'd0,
      ACT_FLOOD     = 2'd1,
      ACT_DROP_TAG  = 2'd2,
      ACT_DROP_LOOP = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRUNK_MASK   = 4'd0,
      CSR_VLANS_LOW    = 4'd1,
      CSR_VLANS_HIGH   = 4'd2,
      CSR_LINK_UP_MASK = 4'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // lookup item that walks the cell row
   typedef struct packed {
      logic              active;
      logic [PORT_W-1:0] ingress;
      logic [VLAN_W-1:0] vlan;
      logic [MAC_W-1:0]  src;
      logic [MAC_W-1:0]  dst;
      logic              learn;
      logic              src_hit;
      logic              placed;
      logic              dst_hit;
      logic [PORT_W-1:0] dst_port;
   } token_type;

   function automatic logic port_valid(input logic [PORT_W-1:0] p);
      return (p >= PORT_W'(1)) && (p <= PORT_W'(PORT_COUNT));
   endfunction

   // mask bit of port p, zero for ports outside the range
   function automatic logic port_bit(input logic [MASK_W-1:0] mask,
                                     input logic [PORT_W-1:0] p);
      logic r;
      r = 1'b0;
      for (int i = 0; i < PORT_COUNT; i++) begin
         if (p == PORT_W'(i + 1)) r = mask[i];
      end
      return r;
   endfunction

   function automatic logic [VLAN_W-1:0] access_vlan(input logic [VLANS_W-1:0] vlans,
                                                     input logic [PORT_W-1:0] p);
      logic [VLAN_W-1:0] r;
      r = DEFAULT_VLAN;
      for (int i = 0; i < PORT_COUNT; i++) begin
         if (p == PORT_W'(i + 1)) r = vlans[VLAN_W*i +: VLAN_W];
      end
      return r;
   endfunction

endpackage

@@ design/vlsf_ifs.sv @@
// Channel interfaces: request (frame header) and response (forwarding result).
// Depends on vlsf_pkg.
interface vlsf_req_if import vlsf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PORT_W-1:0] ingress_port;
   logic [MAC_W-1:0]  src_mac;
   logic [MAC_W-1:0]  dst_mac;
   logic              tag_present;
   logic [VLAN_W-1:0] tag_vlan;
   modport source (output valid, ingress_port, src_mac, dst_mac, tag_present, tag_vlan,
                   input ready);
   modport sink   (input valid, ingress_port, src_mac, dst_mac, tag_present, tag_vlan,
                   output ready);
endinterface

interface vlsf_rsp_if import vlsf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic [MASK_W-1:0] egress_mask;
   logic [MASK_W-1:0] tagged_mask;
   logic [VLAN_W-1:0] resolved_vlan;
   logic              learned;
   logic              table_full;
   modport source (output valid, action, egress_mask, tagged_mask, resolved_vlan, learned,
                   table_full, input ready);
   modport sink   (input valid, action, egress_mask, tagged_mask, resolved_vlan, learned,
                   table_full, output ready);
endinterface

@@ design/vlsf_cell.sv @@
// One address table cell: holds one entry, matches the passing lookup item
// and hands it on through its token register. Depends on vlsf_pkg.
module vlsf_cell import vlsf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  token_type tok_i,
   output token_type tok_o
);

   logic              valid_ff, valid_in;
   logic [VLAN_W-1:0] vlan_ff, vlan_in;
   logic [MAC_W-1:0]  mac_ff, mac_in;
   logic [PORT_W-1:0] port_ff, port_in;
   token_type         tok_ff, tok_in;
   logic              src_m, dst_m, place;

   // match both addresses, claim this cell if it is the first free one
   always_comb begin
      src_m = tok_i.active && valid_ff && (vlan_ff == tok_i.vlan) && (mac_ff == tok_i.src);
      dst_m = tok_i.active && valid_ff && (vlan_ff == tok_i.vlan) && (mac_ff == tok_i.dst);
      place = tok_i.active && !valid_ff && tok_i.learn && !tok_i.src_hit && !tok_i.placed;
      tok_in         = tok_i;
      tok_in.src_hit = tok_i.src_hit | src_m;
      tok_in.placed  = tok_i.placed | place;
      if (dst_m) begin
         tok_in.dst_hit  = 1'b1;
         tok_in.dst_port = port_ff;
      end
   end

   // write a new entry or refresh the port of a known source
   always_comb begin
      valid_in = valid_ff | place;
      vlan_in  = place ? tok_i.vlan : vlan_ff;
      mac_in   = place ? tok_i.src : mac_ff;
      port_in  = (place || (src_m && tok_i.learn)) ? tok_i.ingress : port_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      vlan_ff <= vlan_in;
      mac_ff  <= mac_in;
      port_ff <= port_in;
   end

   assign tok_o = tok_ff;

endmodule

@@ design/vlan_learning_switch_forwarder_unit.sv @@
// VLAN-aware learning bridge forwarder. One header is taken at a time: the
// VLAN is resolved at accept, then a lookup item walks the row of
// TABLE_ENTRIES address cells, one cell per cycle, learning the source and
// finding the destination in one pass. The next header is accepted only once
// the result is loaded into the rsp register; a frame dropped on tag mismatch
// skips the cell row. A finished result waits while the previous one is still
// held on rsp. The table is empty after reset with no clearing pass.
// Configuration is written through csr_*.
module vlan_learning_switch_forwarder_unit import vlsf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   vlsf_req_if.sink             req,
   vlsf_rsp_if.source           rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);
`include "vlan_learning_switch_forwarder_unit_macros.svh"

   localparam logic [MASK_W-1:0] PORT_MASK = MASK_W'((1 << PORT_COUNT) - 1);

   state_type         state_ff, state_in;
   logic [MASK_W-1:0] trunk_ff, link_ff;
   logic [CSR_W-1:0]  vlans_lo_ff, vlans_hi_ff;
   logic [VLANS_W-1:0] vlans;
   token_type         head_tok;
   token_type         tok [0:TABLE_ENTRIES];
   token_type         fin_ff, fin_in;
   logic              drop_ff, drop_in;
   logic              req_fire, rsp_load;
   logic              in_trunk, tag_drop;
   logic [VLAN_W-1:0] in_av, in_vlan;

   logic              rsp_valid_ff, rsp_valid_in;
   action_type        act_ff, act_in;
   logic [MASK_W-1:0] egr_ff, egr_in, tagm_ff, tagm_in;
   logic [VLAN_W-1:0] rvlan_ff, rvlan_in;
   logic              learned_ff, learned_in, full_ff, full_in;

   logic              learned_w, full_w, self_dst, known;
   logic [PORT_W-1:0] kp;
   logic [MASK_W-1:0] flood, uni;

   assign vlans    = {vlans_hi_ff, vlans_lo_ff};
   assign req_fire = req.valid && req.ready;
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp.ready);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         trunk_ff    <= '0;
         link_ff     <= '0;
         vlans_lo_ff <= ACCESS_VLAN_INIT;
         vlans_hi_ff <= ACCESS_VLAN_INIT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRUNK_MASK:   trunk_ff    <= csr_wdata[MASK_W-1:0];
            CSR_VLANS_LOW:    vlans_lo_ff <= csr_wdata;
            CSR_VLANS_HIGH:   vlans_hi_ff <= csr_wdata;
            CSR_LINK_UP_MASK: link_ff     <= csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // resolve the VLAN and build the lookup item
   always_comb begin
      in_trunk = port_bit(trunk_ff, req.ingress_port);
      in_av    = access_vlan(vlans, req.ingress_port);
      tag_drop = !in_trunk && req.tag_present && (req.tag_vlan != in_av);
      in_vlan  = in_trunk ? (req.tag_present ? req.tag_vlan : DEFAULT_VLAN) : in_av;
      head_tok.active   = req_fire && !tag_drop;
      head_tok.ingress  = req.ingress_port;
      head_tok.vlan     = in_vlan;
      head_tok.src      = req.src_mac;
      head_tok.dst      = req.dst_mac;
      head_tok.learn    = !req.src_mac[GROUP_BIT];
      head_tok.src_hit  = 1'b0;
      head_tok.placed   = 1'b0;
      head_tok.dst_hit  = 1'b0;
      head_tok.dst_port = '0;
      drop_in = req_fire ? tag_drop : drop_ff;
      fin_in  = tok[TABLE_ENTRIES].active ? tok[TABLE_ENTRIES] : fin_ff;
   end

   assign tok[0] = head_tok;

   // row of address cells
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      vlsf_cell u_cell (
         .clock (clock),
         .reset (reset),
         .tok_i (tok[i]),
         .tok_o (tok[i+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_fire) state_in = tag_drop ? ST_EMIT : ST_SCAN;
         ST_SCAN: if (tok[TABLE_ENTRIES].active) state_in = ST_EMIT;
         ST_EMIT: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      case (state_ff)
         ST_IDLE: req.ready = 1'b1;
         default: req.ready = 1'b0;
      endcase
   end

   // forwarding decision from the finished lookup
   always_comb begin
      learned_w = fin_ff.learn && (fin_ff.src_hit || fin_ff.placed);
      full_w    = fin_ff.learn && !fin_ff.src_hit && !fin_ff.placed;
      self_dst  = learned_w && (fin_ff.dst == fin_ff.src);
      known     = fin_ff.dst_hit || self_dst;
      kp        = self_dst ? fin_ff.ingress : fin_ff.dst_port;
      flood = '0;
      uni   = '0;
      for (int p = 0; p < PORT_COUNT; p++) begin
         if ((fin_ff.ingress != PORT_W'(p + 1)) && link_ff[p] &&
             (trunk_ff[p] || (vlans[VLAN_W*p +: VLAN_W] == fin_ff.vlan)))
            flood[p] = 1'b1;
         if ((kp == PORT_W'(p + 1)) &&
             (trunk_ff[p] || (vlans[VLAN_W*p +: VLAN_W] == fin_ff.vlan)))
            uni[p] = 1'b1;
      end
      rvlan_in   = fin_ff.vlan;
      learned_in = learned_w;
      full_in    = full_w;
      if (drop_ff) begin
         act_in     = ACT_DROP_TAG;
         egr_in     = '0;
         rvlan_in   = '0;
         learned_in = 1'b0;
         full_in    = 1'b0;
      end else if (fin_ff.dst[GROUP_BIT] || !known) begin
         act_in = ACT_FLOOD;
         egr_in = flood;
      end else if (kp == fin_ff.ingress) begin
         act_in = ACT_DROP_LOOP;
         egr_in = '0;
      end else if (!port_bit(link_ff, kp)) begin
         act_in = ACT_FLOOD;
         egr_in = flood;
      end else begin
         act_in = ACT_UNICAST;
         egr_in = uni;
      end
      egr_in       = egr_in & PORT_MASK;
      tagm_in      = egr_in & trunk_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the finished item and the result register
   always_ff @(posedge clock) begin
      fin_ff  <= fin_in;
      drop_ff <= drop_in;
      if (rsp_load) begin
         act_ff     <= act_in;
         egr_ff     <= egr_in;
         tagm_ff    <= tagm_in;
         rvlan_ff   <= rvlan_in;
         learned_ff <= learned_in;
         full_ff    <= full_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.action        = act_ff;
   assign rsp.egress_mask   = egr_ff;
   assign rsp.tagged_mask   = tagm_ff;
   assign rsp.resolved_vlan = rvlan_ff;
   assign rsp.learned       = learned_ff;
   assign rsp.table_full    = full_ff;

   `VLSF_ASSERT_NEXT(a_accept_leaves_idle, req_fire, state_ff != ST_IDLE)
   `VLSF_ASSERT_NOW(a_row_exit_in_scan, tok[TABLE_ENTRIES].active, state_ff == ST_SCAN)
   `VLSF_ASSERT_NOW(a_loop_no_egress, rsp.valid && (rsp.action == ACT_DROP_LOOP), rsp.egress_mask == '0)

endmodule

@@ tb/vlsf_tb_top.sv @@
// Testbench for the VLAN learning switch forwarder: queue-fed header driver,
// clocked result monitor, and a behavioral forwarding table for prediction.
// Depends on vlsf_pkg, vlsf_ifs and the forwarder top level.
`timescale 1ns / 1ps
module testbench;
   import vlsf_pkg::*;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [MAC_W-1:0]  src;
      logic [MAC_W-1:0]  dst;
      logic              has_tag;
      logic [VLAN_W-1:0] tag;
   } header_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [MASK_W-1:0] egress;
      logic [MASK_W-1:0] tag_mask;
      logic [VLAN_W-1:0] vlan;
      logic              learned;
      logic              full;
   } verdict_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   vlsf_req_if req ();
   vlsf_rsp_if rsp ();

   vlan_learning_switch_forwarder_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // shadow configuration and forwarding table
   logic [MASK_W-1:0]  sh_trunk;
   logic [VLANS_W-1:0] sh_vlans;
   logic [MASK_W-1:0]  sh_link;
   logic               fdb_valid [TABLE_ENTRIES];
   logic [VLAN_W-1:0]  fdb_vlan  [TABLE_ENTRIES];
   logic [MAC_W-1:0]   fdb_mac   [TABLE_ENTRIES];
   logic [PORT_W-1:0]  fdb_port  [TABLE_ENTRIES];

   header_type  pending_headers[$];
   verdict_type expected_verdicts[$];
   int       mismatches = 0;
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;
   int       quiet_cycles = 0;
   bit       in_reset = 1'b1;
   bit       req_taken = 1'b0;

   function automatic logic sh_is_trunk(logic [PORT_W-1:0] p);
      return p >= 1 && p <= PORT_COUNT && sh_trunk[p-1];
   endfunction

   function automatic logic sh_linked(logic [PORT_W-1:0] p);
      return p >= 1 && p <= PORT_COUNT && sh_link[p-1];
   endfunction

   function automatic logic [VLAN_W-1:0] sh_access(logic [PORT_W-1:0] p);
      if (p < 1 || p > PORT_COUNT) return DEFAULT_VLAN;
      return sh_vlans[VLAN_W*(p-1) +: VLAN_W];
   endfunction

   function automatic logic sh_allows(logic [PORT_W-1:0] p, logic [VLAN_W-1:0] v);
      return sh_is_trunk(p) || sh_access(p) == v;
   endfunction

   function automatic int fdb_find(logic [VLAN_W-1:0] v, logic [MAC_W-1:0] m);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (fdb_valid[i] && fdb_vlan[i] == v && fdb_mac[i] == m) return i;
      return -1;
   endfunction

   function automatic logic [MASK_W-1:0] flood_ports(logic [PORT_W-1:0] in_p,
                                                     logic [VLAN_W-1:0] v);
      logic [MASK_W-1:0] m;
      m = '0;
      for (int p = 1; p <= PORT_COUNT; p++)
         if (p != in_p && sh_linked(p) && sh_allows(p, v)) m[p-1] = 1'b1;
      return m;
   endfunction

   // resolve VLAN, learn the source, decide the egress ports
   function automatic verdict_type forward_header(header_type h);
      verdict_type r;
      int idx;
      logic [PORT_W-1:0] kp;
      r = '0;
      if (!sh_is_trunk(h.port)) begin
         if (h.has_tag && h.tag != sh_access(h.port)) begin
            r.action = ACT_DROP_TAG;
            return r;
         end
         r.vlan = sh_access(h.port);
      end else begin
         r.vlan = h.has_tag ? h.tag : DEFAULT_VLAN;
      end
      if (!h.src[GROUP_BIT]) begin
         idx = fdb_find(r.vlan, h.src);
         if (idx < 0)
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (!fdb_valid[i]) begin
                  idx = i;
                  break;
               end
         if (idx >= 0) begin
            fdb_valid[idx] = 1'b1;
            fdb_vlan[idx] = r.vlan;
            fdb_mac[idx] = h.src;
            fdb_port[idx] = h.port;
            r.learned = 1'b1;
         end else begin
            r.full = 1'b1;
         end
      end
      idx = h.dst[GROUP_BIT] ? -1 : fdb_find(r.vlan, h.dst);
      if (idx < 0) begin
         r.action = ACT_FLOOD;
         r.egress = flood_ports(h.port, r.vlan);
      end else begin
         kp = fdb_port[idx];
         if (kp == h.port) begin
            r.action = ACT_DROP_LOOP;
         end else if (!sh_linked(kp)) begin
            r.action = ACT_FLOOD;
            r.egress = flood_ports(h.port, r.vlan);
         end else begin
            r.action = ACT_UNICAST;
            if (sh_allows(kp, r.vlan)) r.egress[kp-1] = 1'b1;
         end
      end
      r.tag_mask = r.egress & sh_trunk;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // drive headers from the pending queue at the falling edge
   always @(negedge clock) begin
      if (in_reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req_taken) begin
            // accepted on the last rising edge; predict now
            expected_verdicts.push_back(forward_header(pending_headers.pop_front()));
         end
         // hold an offered item until it is accepted
         if (!req.valid || req_taken) begin
            if (pending_headers.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req.valid <= 1'b1;
               req.ingress_port <= pending_headers[0].port;
               req.src_mac <= pending_headers[0].src;
               req.dst_mac <= pending_headers[0].dst;
               req.tag_present <= pending_headers[0].has_tag;
               req.tag_vlan <= pending_headers[0].tag;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // check results at the rising edge; watchdog on request and result handshakes
   always @(posedge clock) begin
      verdict_type w;
      req_taken <= req.valid && req.ready;
      if (!in_reset) begin
         if (rsp.valid && rsp.ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("unexpected result", rsp.action, 0);
            end else begin
               w = expected_verdicts.pop_front();
               if (rsp.action !== w.action) report_mismatch("action", rsp.action, w.action);
               if (rsp.egress_mask !== w.egress)
                  report_mismatch("egress_mask", rsp.egress_mask, w.egress);
               if (rsp.tagged_mask !== w.tag_mask)
                  report_mismatch("tagged_mask", rsp.tagged_mask, w.tag_mask);
               if (rsp.resolved_vlan !== w.vlan)
                  report_mismatch("resolved_vlan", rsp.resolved_vlan, w.vlan);
               if (rsp.learned !== w.learned) report_mismatch("learned", rsp.learned, w.learned);
               if (rsp.table_full !== w.full) report_mismatch("table_full", rsp.table_full, w.full);
            end
         end
         if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TRUNK_MASK:   sh_trunk = val[MASK_W-1:0];
         CSR_VLANS_LOW:    sh_vlans[CSR_W-1:0] = val;
         CSR_VLANS_HIGH:   sh_vlans[VLANS_W-1:CSR_W] = val;
         CSR_LINK_UP_MASK: sh_link = val[MASK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_headers.size() > 0 || expected_verdicts.size() > 0 || req.valid)
         @(posedge clock);
      repeat (TABLE_ENTRIES + 8) @(posedge clock);
   endtask

   // small pool of addresses so lookups hit often
   function automatic logic [MAC_W-1:0] pick_mac();
      logic [MAC_W-1:0] m;
      case ($urandom_range(9))
         0: m = MAC_W'({$urandom, $urandom});
         1: m = {MAC_W{1'b1}};
         default: m = {40'h02_00_00_00_00, 8'($urandom_range(23))};
      endcase
      return m;
   endfunction

   function automatic logic [VLAN_W-1:0] pick_vlan();
      return $urandom_range(3) == 0 ? VLAN_W'($urandom) : VLAN_W'($urandom_range(1, 3));
   endfunction

   function automatic header_type random_header();
      header_type h;
      h.port = ($urandom_range(19) == 0) ? PORT_W'($urandom) : PORT_W'($urandom_range(1, 8));
      h.src = pick_mac();
      h.dst = pick_mac();
      h.has_tag = 1'($urandom_range(1));
      h.tag = ($urandom_range(3) == 0) ? VLAN_W'($urandom) : pick_vlan();
      return h;
   endfunction

   function automatic logic [CSR_W-1:0] random_vlans();
      logic [CSR_W-1:0] v;
      for (int i = 0; i < 4; i++) v[VLAN_W*i +: VLAN_W] = pick_vlan();
      return v;
   endfunction

   task automatic random_config();
      write_csr(CSR_TRUNK_MASK, CSR_W'($urandom_range(255)));
      write_csr(CSR_VLANS_LOW, random_vlans());
      write_csr(CSR_VLANS_HIGH, random_vlans());
      write_csr(CSR_LINK_UP_MASK, CSR_W'($urandom_range(255)));
   endtask

   initial begin
      header_type h;
      req.valid = 1'b0;
      req.ingress_port = '0;
      req.src_mac = '0;
      req.dst_mac = '0;
      req.tag_present = 1'b0;
      req.tag_vlan = '0;
      rsp.ready = 1'b0;
      sh_trunk = '0;
      sh_vlans = {ACCESS_VLAN_INIT, ACCESS_VLAN_INIT};
      sh_link = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         fdb_valid[i] = 1'b0;
         fdb_vlan[i] = '0;
         fdb_mac[i] = '0;
         fdb_port[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      in_reset = 1'b0;

      // directed: reset config, then extremes and special cases
      pending_headers.push_back('{1, 48'h0200_0000_0001, {MAC_W{1'b1}}, 0, 0});
      drain();
      write_csr(CSR_TRUNK_MASK, 48'h0000_0000_00F0);
      write_csr(CSR_VLANS_LOW, 48'h0020_0200_2002);
      write_csr(CSR_VLANS_HIGH, {CSR_W{1'b1}});
      write_csr(CSR_LINK_UP_MASK, 48'h0000_0000_00FF);
      write_csr(csr_index_type'(4'd9), {CSR_W{1'b1}});
      pending_headers.push_back('{1, 48'h0200_0000_0001, 48'h0200_0000_0002, 0, 0});
      pending_headers.push_back('{2, 48'h0200_0000_0002, 48'h0200_0000_0001, 1, 2});
      pending_headers.push_back('{2, 48'h0200_0000_0002, 48'h0200_0000_0001, 1, 7});
      pending_headers.push_back('{1, 48'h0200_0000_0001, 48'h0200_0000_0001, 0, 0});
      pending_headers.push_back('{5, 48'h0200_0000_0005, {MAC_W{1'b1}}, 0, 0});
      pending_headers.push_back('{6, 48'h0200_0000_0006, 48'h0200_0000_0005, 1, 1});
      pending_headers.push_back('{8, {MAC_W{1'b1}}, 48'h0100_5E00_0001, 1, 12'hFFF});
      pending_headers.push_back('{0, 48'h0200_0000_0009, 48'h0, 1, 1});
      pending_headers.push_back('{15, 48'h0200_0000_000F, 48'h0200_0000_0009, 0, 0});
      pending_headers.push_back('{1, 48'h0200_0000_0003, 48'h0200_0000_000F, 0, 0});
      pending_headers.push_back('{3, 48'hFEFF_FFFF_FFFF, 48'h0200_0000_0001, 1, 2});
      drain();
      // destination on an unlinked port, and a destination unknown in the tag's VLAN
      write_csr(CSR_LINK_UP_MASK, 48'h0000_0000_00FE);
      pending_headers.push_back('{2, 48'h0200_0000_0007, 48'h0200_0000_0001, 0, 0});
      pending_headers.push_back('{5, 48'h0200_0000_0008, 48'h0200_0000_0002, 1, 3});
      drain();
      // fill the table so new sources see it full
      write_csr(CSR_TRUNK_MASK, 48'h0000_0000_00FF);
      write_csr(CSR_LINK_UP_MASK, 48'h0);
      for (int i = 0; i < TABLE_ENTRIES + 4; i++)
         pending_headers.push_back('{8, {24'h020000, 24'(i + 1000)}, {MAC_W{1'b1}}, 1, 12'd77});
      drain();
      pending_headers.push_back('{3, 48'h0200_0000_0001, 48'h0200_0000_0002, 0, 0});
      drain();
      // reload to get a fresh table is impossible; keep learning into a full table
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 85 : 0;
         recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 16 : 0;
         for (int k = 0; k < 6; k++) begin
            random_config();
            if (k == 5) write_csr(CSR_LINK_UP_MASK, 48'hFF);
            for (int n = 0; n < 88; n++) begin
               h = random_header();
               pending_headers.push_back(h);
            end
            drain();
         end
      end
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
